// ===== rtl/core/hurf_pkg.sv =====
// hurf_pkg: shared constants, codes and helper functions of the url rule filter
// no dependencies; imported by every module of the block but hurf_queue
package hurf_pkg;

	localparam int DEF_MAX_RULES    = 16;
	localparam int DEF_SITE_BYTES   = 64;
	localparam int DEF_FOLDER_BYTES = 64;
	localparam int DEF_PACKET_BYTES = 2048;

	localparam logic [15:0] PLAIN_PORT = 16'd80;

	localparam logic [2:0] KIND_PKT    = 3'd0;
	localparam logic [2:0] KIND_SITE   = 3'd1;
	localparam logic [2:0] KIND_FOLDER = 3'd2;
	localparam logic [2:0] KIND_COMMIT = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	localparam logic [2:0] REASON_NOT_HTTP = 3'd0;
	localparam logic [2:0] REASON_MET      = 3'd1;
	localparam logic [2:0] REASON_FAILED   = 3'd2;
	localparam logic [2:0] REASON_NO_SITE  = 3'd3;
	localparam logic [2:0] REASON_STORED   = 3'd4;
	localparam logic [2:0] REASON_FULL     = 3'd5;

	localparam logic [1:0] MTH_GET  = 2'd0;
	localparam logic [1:0] MTH_POST = 2'd1;
	localparam logic [1:0] MTH_HEAD = 2'd2;

	typedef struct packed {
		logic       decide;
		logic       cut;
		logic       excl;
		logic [2:0] reason;
		logic [3:0] idx;
	} job_ctl_t;

	function automatic logic [7:0] method_byte(input logic [1:0] m, input logic [2:0] k);
		logic [39:0] w;
		case (m)
			MTH_GET:  w = {"GET ", 8'h00};
			MTH_POST: w = "POST ";
			MTH_HEAD: w = "HEAD ";
			default:  w = '0;
		endcase
		return (k < 3'd5) ? w[39 - 8 * k -: 8] : 8'h00;
	endfunction

	function automatic logic [15:0] pow10(input logic [2:0] i);
		case (i)
			3'd0:    return 16'd10000;
			3'd1:    return 16'd1000;
			3'd2:    return 16'd100;
			3'd3:    return 16'd10;
			default: return 16'd1;
		endcase
	endfunction

endpackage

// ===== rtl/core/hurf_queue.sv =====
// hurf_queue: two-entry transaction queue between the front and back parts
// depends on nothing but its WIDTH parameter
module hurf_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			mem_q[0] <= '0;
			mem_q[1] <= '0;
		end else begin
			if (push) begin
				mem_q[wr_ptr_q] <= wr_data;
				wr_ptr_q        <= ~wr_ptr_q;
			end
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== rtl/core/hurf_front.sv =====
// hurf_front: accepts input transactions, keeps the fill counters and rule count,
// issues store writes and queues decide and commit jobs; uses hurf_pkg
module hurf_front
	import hurf_pkg::*;
#(
	parameter int MAX_RULES    = DEF_MAX_RULES,
	parameter int SITE_BYTES   = DEF_SITE_BYTES,
	parameter int FOLDER_BYTES = DEF_FOLDER_BYTES,
	parameter int PACKET_BYTES = DEF_PACKET_BYTES,
	localparam int PL_W = $clog2(PACKET_BYTES + 1),
	localparam int PA_W = $clog2(PACKET_BYTES),
	localparam int RC_W = $clog2(MAX_RULES + 1),
	localparam int RW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
	localparam int SLW  = $clog2(SITE_BYTES + 1),
	localparam int FLW  = $clog2(FOLDER_BYTES + 1),
	localparam int SA_W = $clog2(MAX_RULES * SITE_BYTES),
	localparam int FA_W = $clog2(MAX_RULES * FOLDER_BYTES)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [2:0]      kind,
	input  logic [7:0]      data_byte,
	input  logic [15:0]     port_number,
	input  logic            last,
	input  logic            cfg_wr_en,
	input  logic            cfg_wr_data,
	input  logic            back_done,
	input  logic            q_full,
	output logic            q_push,
	output job_ctl_t        q_ctl,
	output logic [PL_W-1:0] q_len,
	output logic [RC_W-1:0] q_rc,
	output logic            pkt_we,
	output logic [PA_W-1:0] pkt_waddr,
	output logic [7:0]      str_wdata,
	output logic            site_we,
	output logic [SA_W-1:0] site_waddr,
	output logic            folder_we,
	output logic [FA_W-1:0] folder_waddr,
	output logic            rule_we,
	output logic [RW-1:0]   rule_waddr,
	output logic [15:0]     rule_wport,
	output logic [SLW-1:0]  rule_wslen,
	output logic [FLW-1:0]  rule_wflen
);

	logic [PL_W-1:0] pkt_len_q;
	logic            cut_q;
	logic [RC_W-1:0] rc_q;
	logic [SLW-1:0]  cur_slen_q;
	logic [FLW-1:0]  cur_flen_q;
	logic            excl_q;
	logic            busy_q;

	logic acc;
	logic room;
	logic pkt_room;
	logic site_room;
	logic folder_room;

	assign in_stall    = busy_q | q_full;
	assign acc         = in_valid & ~in_stall;
	assign room        = (rc_q < RC_W'(MAX_RULES));
	assign pkt_room    = (pkt_len_q < PL_W'(PACKET_BYTES));
	assign site_room   = (cur_slen_q < SLW'(SITE_BYTES));
	assign folder_room = (cur_flen_q < FLW'(FOLDER_BYTES));

	assign pkt_we       = acc && (kind == KIND_PKT) && pkt_room;
	assign pkt_waddr    = PA_W'(pkt_len_q);
	assign str_wdata    = data_byte;
	assign site_we      = acc && (kind == KIND_SITE) && (data_byte != 8'h00) && room && site_room;
	assign folder_we    = acc && (kind == KIND_FOLDER) && (data_byte != 8'h00) && room
		&& folder_room;
	assign site_waddr   = SA_W'(rc_q) * SA_W'(SITE_BYTES) + SA_W'(cur_slen_q);
	assign folder_waddr = FA_W'(rc_q) * FA_W'(FOLDER_BYTES) + FA_W'(cur_flen_q);
	assign rule_we      = acc && (kind == KIND_COMMIT) && room;
	assign rule_waddr   = RW'(rc_q);
	assign rule_wport   = port_number;
	assign rule_wslen   = cur_slen_q;
	assign rule_wflen   = cur_flen_q;

	assign q_push = acc && (((kind == KIND_PKT) && last) || (kind == KIND_COMMIT));
	assign q_len  = pkt_room ? (pkt_len_q + PL_W'(1)) : pkt_len_q;
	assign q_rc   = rc_q;

	always_comb begin
		q_ctl.decide = (kind == KIND_PKT);
		q_ctl.cut    = (kind == KIND_PKT) ? (cut_q | ~pkt_room) : cut_q;
		q_ctl.excl   = excl_q;
		q_ctl.reason = room ? REASON_STORED : REASON_FULL;
		q_ctl.idx    = room ? 4'(rc_q) : 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_len_q  <= '0;
			cut_q      <= 1'b0;
			rc_q       <= '0;
			cur_slen_q <= '0;
			cur_flen_q <= '0;
			excl_q     <= 1'b0;
			busy_q     <= 1'b0;
		end else begin
			if (cfg_wr_en)
				excl_q <= cfg_wr_data;
			if (back_done)
				busy_q <= 1'b0;
			if (acc) begin
				case (kind)
					KIND_PKT: begin
						if (pkt_room)
							pkt_len_q <= pkt_len_q + PL_W'(1);
						else
							cut_q <= 1'b1;
						if (last) begin
							pkt_len_q <= '0;
							cut_q     <= 1'b0;
							busy_q    <= 1'b1;
						end
					end
					KIND_SITE: begin
						if (data_byte != 8'h00) begin
							if (room && site_room)
								cur_slen_q <= cur_slen_q + SLW'(1);
							else
								cut_q <= 1'b1;
						end
					end
					KIND_FOLDER: begin
						if (data_byte != 8'h00) begin
							if (room && folder_room)
								cur_flen_q <= cur_flen_q + FLW'(1);
							else
								cut_q <= 1'b1;
						end
					end
					KIND_COMMIT: begin
						if (room) begin
							rc_q       <= rc_q + RC_W'(1);
							cur_slen_q <= '0;
							cur_flen_q <= '0;
						end
						cut_q <= 1'b0;
					end
					KIND_CLEAR: begin
						rc_q       <= '0;
						cur_slen_q <= '0;
						cur_flen_q <= '0;
						cut_q      <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== rtl/core/hurf_back.sv =====
// hurf_back: holds the packet and rule memories, runs the payload scan sequencer
// and drives the result register; uses hurf_pkg
module hurf_back
	import hurf_pkg::*;
#(
	parameter int MAX_RULES    = DEF_MAX_RULES,
	parameter int SITE_BYTES   = DEF_SITE_BYTES,
	parameter int FOLDER_BYTES = DEF_FOLDER_BYTES,
	parameter int PACKET_BYTES = DEF_PACKET_BYTES,
	localparam int PL_W = $clog2(PACKET_BYTES + 1),
	localparam int PA_W = $clog2(PACKET_BYTES),
	localparam int RC_W = $clog2(MAX_RULES + 1),
	localparam int RW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
	localparam int SLW  = $clog2(SITE_BYTES + 1),
	localparam int FLW  = $clog2(FOLDER_BYTES + 1),
	localparam int SA_W = $clog2(MAX_RULES * SITE_BYTES),
	localparam int FA_W = $clog2(MAX_RULES * FOLDER_BYTES)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	output logic            q_pop,
	input  job_ctl_t        q_ctl,
	input  logic [PL_W-1:0] q_len,
	input  logic [RC_W-1:0] q_rc,
	input  logic            pkt_we,
	input  logic [PA_W-1:0] pkt_waddr,
	input  logic [7:0]      str_wdata,
	input  logic            site_we,
	input  logic [SA_W-1:0] site_waddr,
	input  logic            folder_we,
	input  logic [FA_W-1:0] folder_waddr,
	input  logic            rule_we,
	input  logic [RW-1:0]   rule_waddr,
	input  logic [15:0]     rule_wport,
	input  logic [SLW-1:0]  rule_wslen,
	input  logic [FLW-1:0]  rule_wflen,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            verdict,
	output logic [2:0]      reason,
	output logic [3:0]      rule_index,
	output logic            overflow,
	output logic            back_done
);

	localparam int NW  = (SLW > FLW) ? SLW : FLW;
	localparam int EW  = PL_W + 1;
	localparam int RMW = 16 + SLW + FLW;

	typedef enum logic [3:0] {
		ST_IDLE, ST_H0, ST_H0W, ST_H1, ST_H1W, ST_LEN, ST_LENW, ST_RULE,
		ST_RULEW, ST_SCHK, ST_SCMP, ST_SRES, ST_DIG, ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		PH_GET, PH_POST, PH_HEAD, PH_SITE, PH_FOLDER, PH_PORT
	} phase_t;

	logic [7:0]     pkt_mem [PACKET_BYTES];
	logic [7:0]     site_mem [MAX_RULES * SITE_BYTES];
	logic [7:0]     folder_mem [MAX_RULES * FOLDER_BYTES];
	logic [RMW-1:0] rule_mem [MAX_RULES];

	logic [7:0]     pkt_rd_q;
	logic [7:0]     site_rd_q;
	logic [7:0]     folder_rd_q;
	logic [RMW-1:0] rule_rd_q;

	logic [PA_W-1:0] pkt_raddr;
	logic [SA_W-1:0] site_raddr;
	logic [FA_W-1:0] folder_raddr;
	logic [RW-1:0]   rule_raddr;

	state_t          state_q;
	phase_t          phase_q;
	job_ctl_t        job_q;
	logic [PL_W-1:0] len_q;
	logic [RC_W-1:0] rc_q;
	logic [5:0]      ihl4_q;
	logic [6:0]      off_q;
	logic [PL_W-1:0] plen_q;
	logic [PL_W-1:0] s_q;
	logic [NW-1:0]   k_q;
	logic [NW-1:0]   nlen_q;
	logic [RC_W-1:0] r_q;
	logic [15:0]     port_q;
	logic [FLW-1:0]  flen_q;
	logic            hit_q;
	logic [15:0]     v_q;
	logic [3:0]      dig_q [5];
	logic [2:0]      pi_q;
	logic            res_verdict_q;
	logic [2:0]      res_reason_q;
	logic [3:0]      res_idx_q;
	logic            out_valid_q;
	logic            verdict_q;
	logic [2:0]      reason_q;
	logic [3:0]      rule_index_q;
	logic            overflow_q;
	logic            done_q;

	logic [EW-1:0] pos;
	logic [2:0]    first;
	logic [2:0]    didx;
	logic [7:0]    needle;
	logic [7:0]    hb;
	logic          cond;

	always_ff @(posedge clk) begin
		if (pkt_we)
			pkt_mem[pkt_waddr] <= str_wdata;
		pkt_rd_q <= pkt_mem[pkt_raddr];
	end

	always_ff @(posedge clk) begin
		if (site_we)
			site_mem[site_waddr] <= str_wdata;
		site_rd_q <= site_mem[site_raddr];
	end

	always_ff @(posedge clk) begin
		if (folder_we)
			folder_mem[folder_waddr] <= str_wdata;
		folder_rd_q <= folder_mem[folder_raddr];
	end

	always_ff @(posedge clk) begin
		if (rule_we)
			rule_mem[rule_waddr] <= {rule_wport, rule_wslen, rule_wflen};
		rule_rd_q <= rule_mem[rule_raddr];
	end

	assign pos = EW'(off_q) + EW'(s_q) + EW'(k_q);

	always_comb begin
		case (state_q)
			ST_H0:   pkt_raddr = '0;
			ST_H1:   pkt_raddr = PA_W'(ihl4_q) + PA_W'(12);
			ST_LEN:  pkt_raddr = PA_W'(off_q) + PA_W'(plen_q);
			default: pkt_raddr = PA_W'(pos);
		endcase
	end

	assign site_raddr   = SA_W'(r_q) * SA_W'(SITE_BYTES) + SA_W'(k_q);
	assign folder_raddr = FA_W'(r_q) * FA_W'(FOLDER_BYTES) + FA_W'(k_q);
	assign rule_raddr   = RW'(r_q);

	// leading digit of the port text
	always_comb begin
		first = 3'd4;
		for (int i = 3; i >= 0; i--)
			if (dig_q[i] != 4'd0)
				first = 3'(i);
	end

	assign didx = first + k_q[2:0] - 3'd1;

	always_comb begin
		case (phase_q)
			PH_GET, PH_POST, PH_HEAD: needle = method_byte(phase_q[1:0], k_q[2:0]);
			PH_SITE:   needle = site_rd_q;
			PH_FOLDER: needle = folder_rd_q;
			PH_PORT: begin
				if (k_q == '0)
					needle = ":";
				else if (didx <= 3'd4)
					needle = {4'h3, dig_q[didx]};
				else
					needle = 8'h00;
			end
			default: needle = 8'h00;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_H0W:  hb = (len_q != '0) ? pkt_rd_q : 8'h00;
			ST_H1W:  hb = ((EW'(ihl4_q) + EW'(12)) < EW'(len_q)) ? pkt_rd_q : 8'h00;
			default: hb = 8'h00;
		endcase
	end

	// outcome of the deciding rule, from the folder or port search
	assign cond = (phase_q == PH_FOLDER) ? (hit_q && (port_q == PLAIN_PORT)) : hit_q;

	assign q_pop      = (state_q == ST_IDLE) && !q_empty;
	assign out_valid  = out_valid_q;
	assign verdict    = verdict_q;
	assign reason     = reason_q;
	assign rule_index = rule_index_q;
	assign overflow   = overflow_q;
	assign back_done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= PH_GET;
			job_q         <= '0;
			len_q         <= '0;
			rc_q          <= '0;
			ihl4_q        <= '0;
			off_q         <= '0;
			plen_q        <= '0;
			s_q           <= '0;
			k_q           <= '0;
			nlen_q        <= '0;
			r_q           <= '0;
			port_q        <= '0;
			flen_q        <= '0;
			hit_q         <= 1'b0;
			v_q           <= '0;
			for (int i = 0; i < 5; i++)
				dig_q[i] <= '0;
			pi_q          <= '0;
			res_verdict_q <= 1'b0;
			res_reason_q  <= REASON_NOT_HTTP;
			res_idx_q     <= '0;
			out_valid_q   <= 1'b0;
			verdict_q     <= 1'b0;
			reason_q      <= REASON_NOT_HTTP;
			rule_index_q  <= '0;
			overflow_q    <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						job_q <= q_ctl;
						len_q <= q_len;
						rc_q  <= q_rc;
						if (q_ctl.decide) begin
							state_q <= ST_H0;
						end else begin
							res_verdict_q <= 1'b0;
							res_reason_q  <= q_ctl.reason;
							res_idx_q     <= q_ctl.idx;
							state_q       <= ST_EMIT;
						end
					end
				end
				ST_H0: state_q <= ST_H0W;
				ST_H0W: begin
					ihl4_q  <= {hb[3:0], 2'b00};
					state_q <= ST_H1;
				end
				ST_H1: state_q <= ST_H1W;
				ST_H1W: begin
					off_q   <= 7'(ihl4_q) + 7'({hb[7:4], 2'b00});
					plen_q  <= '0;
					state_q <= ST_LEN;
				end
				ST_LEN: begin
					if ((EW'(off_q) + EW'(plen_q)) < EW'(len_q)) begin
						state_q <= ST_LENW;
					end else begin
						phase_q <= PH_GET;
						nlen_q  <= NW'(4);
						s_q     <= '0;
						k_q     <= '0;
						state_q <= ST_SCHK;
					end
				end
				ST_LENW: begin
					if (pkt_rd_q != 8'h00) begin
						plen_q  <= plen_q + PL_W'(1);
						state_q <= ST_LEN;
					end else begin
						phase_q <= PH_GET;
						nlen_q  <= NW'(4);
						s_q     <= '0;
						k_q     <= '0;
						state_q <= ST_SCHK;
					end
				end
				ST_SCHK: begin
					if (nlen_q == '0) begin
						hit_q   <= 1'b1;
						state_q <= ST_SRES;
					end else if ((EW'(s_q) + EW'(nlen_q)) > EW'(plen_q)) begin
						hit_q   <= 1'b0;
						state_q <= ST_SRES;
					end else begin
						state_q <= ST_SCMP;
					end
				end
				ST_SCMP: begin
					if (pkt_rd_q == needle) begin
						if ((k_q + NW'(1)) == nlen_q) begin
							hit_q   <= 1'b1;
							state_q <= ST_SRES;
						end else begin
							k_q     <= k_q + NW'(1);
							state_q <= ST_SCHK;
						end
					end else begin
						s_q     <= s_q + PL_W'(1);
						k_q     <= '0;
						state_q <= ST_SCHK;
					end
				end
				ST_SRES: begin
					s_q <= '0;
					k_q <= '0;
					case (phase_q)
						PH_GET, PH_POST: begin
							if (hit_q) begin
								r_q     <= '0;
								state_q <= ST_RULE;
							end else begin
								phase_q <= (phase_q == PH_GET) ? PH_POST : PH_HEAD;
								nlen_q  <= NW'(5);
								state_q <= ST_SCHK;
							end
						end
						PH_HEAD: begin
							if (hit_q) begin
								r_q     <= '0;
								state_q <= ST_RULE;
							end else begin
								res_verdict_q <= 1'b0;
								res_reason_q  <= REASON_NOT_HTTP;
								res_idx_q     <= '0;
								state_q       <= ST_EMIT;
							end
						end
						PH_SITE: begin
							if (hit_q) begin
								phase_q <= PH_FOLDER;
								nlen_q  <= NW'(flen_q);
								state_q <= ST_SCHK;
							end else begin
								r_q     <= r_q + RC_W'(1);
								state_q <= ST_RULE;
							end
						end
						PH_FOLDER: begin
							if (hit_q && (port_q != PLAIN_PORT)) begin
								v_q  <= port_q;
								pi_q <= '0;
								for (int i = 0; i < 5; i++)
									dig_q[i] <= '0;
								state_q <= ST_DIG;
							end else begin
								res_verdict_q <= job_q.excl ? cond : ~cond;
								res_reason_q  <= cond ? REASON_MET : REASON_FAILED;
								res_idx_q     <= 4'(r_q);
								state_q       <= ST_EMIT;
							end
						end
						default: begin
							res_verdict_q <= job_q.excl ? cond : ~cond;
							res_reason_q  <= cond ? REASON_MET : REASON_FAILED;
							res_idx_q     <= 4'(r_q);
							state_q       <= ST_EMIT;
						end
					endcase
				end
				ST_RULE: begin
					if (r_q >= rc_q) begin
						res_verdict_q <= ~job_q.excl;
						res_reason_q  <= REASON_NO_SITE;
						res_idx_q     <= '0;
						state_q       <= ST_EMIT;
					end else begin
						state_q <= ST_RULEW;
					end
				end
				ST_RULEW: begin
					port_q  <= rule_rd_q[RMW-1 -: 16];
					flen_q  <= rule_rd_q[FLW-1:0];
					phase_q <= PH_SITE;
					nlen_q  <= NW'(rule_rd_q[FLW +: SLW]);
					s_q     <= '0;
					k_q     <= '0;
					state_q <= ST_SCHK;
				end
				ST_DIG: begin
					if (pi_q == 3'd4) begin
						dig_q[4] <= v_q[3:0];
						phase_q  <= PH_PORT;
						nlen_q   <= NW'(3'd6 - first);
						s_q      <= '0;
						k_q      <= '0;
						state_q  <= ST_SCHK;
					end else if (v_q >= pow10(pi_q)) begin
						v_q         <= v_q - pow10(pi_q);
						dig_q[pi_q] <= dig_q[pi_q] + 4'd1;
					end else begin
						pi_q <= pi_q + 3'd1;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						verdict_q    <= res_verdict_q;
						reason_q     <= res_reason_q;
						rule_index_q <= res_idx_q;
						overflow_q   <= job_q.cut;
						done_q       <= job_q.decide;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/http_url_rule_filter.sv =====
// a rule byte or packet byte without last goes straight into its store; a commit is
// queued, and hurf_back then loads its result into the output register
// a last packet byte queues a decide job: hurf_back first steps through the packet to find
// the payload, then runs a byte-by-byte shift-and-compare scan per method word and per
// rule string; input is stalled from the last byte until the registered done of hurf_back
// clears the busy flag, and while two jobs wait in the queue
// reset clears counters, rule count, mode and sequencer; the memories are not cleared
module http_url_rule_filter
	import hurf_pkg::*;
#(
	parameter int MAX_RULES    = DEF_MAX_RULES,
	parameter int SITE_BYTES   = DEF_SITE_BYTES,
	parameter int FOLDER_BYTES = DEF_FOLDER_BYTES,
	parameter int PACKET_BYTES = DEF_PACKET_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic [15:0] port_number,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        verdict,
	output logic [2:0]  reason,
	output logic [3:0]  rule_index,
	output logic        overflow
);

	localparam int PL_W = $clog2(PACKET_BYTES + 1);
	localparam int PA_W = $clog2(PACKET_BYTES);
	localparam int RC_W = $clog2(MAX_RULES + 1);
	localparam int RW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int SLW  = $clog2(SITE_BYTES + 1);
	localparam int FLW  = $clog2(FOLDER_BYTES + 1);
	localparam int SA_W = $clog2(MAX_RULES * SITE_BYTES);
	localparam int FA_W = $clog2(MAX_RULES * FOLDER_BYTES);
	localparam int QW   = $bits(job_ctl_t) + PL_W + RC_W;

	logic            q_push;
	logic            q_pop;
	logic            q_full;
	logic            q_empty;
	job_ctl_t        wr_ctl;
	logic [PL_W-1:0] wr_len;
	logic [RC_W-1:0] wr_rc;
	job_ctl_t        rd_ctl;
	logic [PL_W-1:0] rd_len;
	logic [RC_W-1:0] rd_rc;
	logic [QW-1:0]   q_rd_data;
	logic            back_done;

	logic            pkt_we;
	logic [PA_W-1:0] pkt_waddr;
	logic [7:0]      str_wdata;
	logic            site_we;
	logic [SA_W-1:0] site_waddr;
	logic            folder_we;
	logic [FA_W-1:0] folder_waddr;
	logic            rule_we;
	logic [RW-1:0]   rule_waddr;
	logic [15:0]     rule_wport;
	logic [SLW-1:0]  rule_wslen;
	logic [FLW-1:0]  rule_wflen;

	hurf_front #(
		.MAX_RULES    (MAX_RULES),
		.SITE_BYTES   (SITE_BYTES),
		.FOLDER_BYTES (FOLDER_BYTES),
		.PACKET_BYTES (PACKET_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.port_number  (port_number),
		.last         (last),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.back_done    (back_done),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_ctl        (wr_ctl),
		.q_len        (wr_len),
		.q_rc         (wr_rc),
		.pkt_we       (pkt_we),
		.pkt_waddr    (pkt_waddr),
		.str_wdata    (str_wdata),
		.site_we      (site_we),
		.site_waddr   (site_waddr),
		.folder_we    (folder_we),
		.folder_waddr (folder_waddr),
		.rule_we      (rule_we),
		.rule_waddr   (rule_waddr),
		.rule_wport   (rule_wport),
		.rule_wslen   (rule_wslen),
		.rule_wflen   (rule_wflen)
	);

	hurf_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data ({wr_ctl, wr_len, wr_rc}),
		.pop     (q_pop),
		.rd_data (q_rd_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign {rd_ctl, rd_len, rd_rc} = q_rd_data;

	hurf_back #(
		.MAX_RULES    (MAX_RULES),
		.SITE_BYTES   (SITE_BYTES),
		.FOLDER_BYTES (FOLDER_BYTES),
		.PACKET_BYTES (PACKET_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.q_ctl        (rd_ctl),
		.q_len        (rd_len),
		.q_rc         (rd_rc),
		.pkt_we       (pkt_we),
		.pkt_waddr    (pkt_waddr),
		.str_wdata    (str_wdata),
		.site_we      (site_we),
		.site_waddr   (site_waddr),
		.folder_we    (folder_we),
		.folder_waddr (folder_waddr),
		.rule_we      (rule_we),
		.rule_waddr   (rule_waddr),
		.rule_wport   (rule_wport),
		.rule_wslen   (rule_wslen),
		.rule_wflen   (rule_wflen),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.verdict      (verdict),
		.reason       (reason),
		.rule_index   (rule_index),
		.overflow     (overflow),
		.back_done    (back_done)
	);

endmodule

// ===== rtl/core/hurf_checker.sv =====
// hurf_checker: port-level assertions on the url rule filter result channel
// uses hurf_pkg; bound to http_url_rule_filter at the end of this file
module hurf_checker
	import hurf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        verdict,
	input logic [2:0]  reason,
	input logic [3:0]  rule_index
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(reason)
			&& $stable(rule_index))
		else $error("result changed while stalled");

	a_commit_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reason == REASON_STORED || reason == REASON_FULL) |-> !verdict)
		else $error("commit transaction gave a drop verdict");

	a_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reason == REASON_FULL || reason == REASON_NO_SITE
			|| reason == REASON_NOT_HTTP) |-> rule_index == 4'd0)
		else $error("rule index set without a deciding rule");

	a_not_http_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reason == REASON_NOT_HTTP |-> !verdict)
		else $error("non-http payload dropped");

endmodule

bind http_url_rule_filter hurf_checker u_hurf_checker (.*);
